[hw/rtl/input_axis_button_conditioner_assert.svh]
// Assertion macros shared by the input axis and button conditioner modules.
// Needs nothing else; each macro checks one implication on the rising clock edge.
`ifndef INPUT_AXIS_BUTTON_CONDITIONER_ASSERT_SVH
`define INPUT_AXIS_BUTTON_CONDITIONER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define IABC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IABC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/iabc_pkg.sv]
// Shared types, widths and constants of the input axis and button conditioner.
// Used by the controller, the datapath and the top level; depends on nothing.
package iabc_pkg;

   // Fixed field widths.
   localparam int SAMPLE_BITS   = 16;
   localparam int FRAC_BITS     = SAMPLE_BITS - 1;
   localparam int TIME_BITS     = 32;
   localparam int ACTION_BITS   = 3;
   localparam int INDEX_BITS    = 4;
   localparam int RESULT_BITS   = 24;

   // Default storage sizes handed to the top-level parameters.
   localparam int BUTTON_COUNT_DEF = 16;
   localparam int AXIS_COUNT_DEF   = 8;

   // Configuration port and register widths.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int SRC_BITS       = 4;
   localparam int MODE_BITS      = 2;
   localparam int DZ_BITS        = 15;
   localparam int SENS_BITS      = 16;
   localparam int BTN_SEL_BITS   = 5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_AXIS_SOURCE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AXIS_INVERTED   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AXIS_RANGE_MODE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEAD_ZONE       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SENSITIVITY     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POSITIVE_BUTTON = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEGATIVE_BUTTON = 3'd6;

   localparam logic [SRC_BITS-1:0]     AXIS_SOURCE_RST = 4'd8;
   localparam logic [SENS_BITS-1:0]    SENSITIVITY_RST = 16'd256;
   localparam logic [BTN_SEL_BITS-1:0] BUTTON_SEL_RST  = 5'd16;

   localparam logic [MODE_BITS-1:0] RANGE_FULL     = 2'd0;
   localparam logic [MODE_BITS-1:0] RANGE_FORWARD  = 2'd1;
   localparam logic [MODE_BITS-1:0] RANGE_BACKWARD = 2'd2;

   // Conditioning arithmetic, Q.24 internally.
   localparam int X_BITS      = 26;
   localparam int MAG_BITS    = 25;
   localparam int DZQ_BITS    = 24;
   localparam int DZ_SHIFT    = DZQ_BITS - DZ_BITS;
   localparam int FULL_SHIFT  = 24 - FRAC_BITS;
   localparam int HALF_SHIFT  = 23 - FRAC_BITS;
   localparam int PROD_BITS   = MAG_BITS + SENS_BITS;
   localparam int GAIN_SHIFT  = 7;
   localparam int NUM_BITS    = PROD_BITS + GAIN_SHIFT;
   localparam int DIV_STEPS   = RESULT_BITS;
   localparam int CNT_BITS    = $clog2(DIV_STEPS);

   localparam logic signed [X_BITS-1:0] HALF_Q24 = 26'sh0800000;
   localparam logic [MAG_BITS-1:0]      ONE_Q24  = 25'h1000000;

   localparam logic [RESULT_BITS-1:0] SAT_MAX      = 24'h7FFFFF;
   localparam logic [RESULT_BITS-1:0] SAT_MIN      = 24'h800000;
   localparam logic [RESULT_BITS-1:0] PLUS_ONE_Q15 = 24'h008000;
   localparam logic [RESULT_BITS-1:0] MINUS_ONE_Q15 = 24'hFF8000;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_UPDATE_BUTTON = 3'd0,
      ACT_UPDATE_AXIS   = 3'd1,
      ACT_END_FRAME     = 3'd2,
      ACT_QUERY_BUTTON  = 3'd3,
      ACT_QUERY_AXIS    = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_AXIS_READ,
      ST_MULTIPLY,
      ST_DIV_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic wr_button;
      logic wr_axis;
      logic end_frame;
      logic rsp_button;
      logic rsp_unbound;
      logic rd_negative;
      logic load_axis;
      logic multiply;
      logic div_init;
      logic div_step;
      logic rsp_axis;
   } cmd_type;

   typedef struct packed {
      action_type act;
      logic       axis_bound;
   } stat_type;

endpackage

[hw/rtl/iabc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used by the datapath for the stamp and axis sample stores; no dependencies.
module iabc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/iabc_ctrl.sv]
// Controller state machine of the conditioner: sequences requests and the divider.
// Depends on iabc_pkg and the assertion macro header.
`include "input_axis_button_conditioner_assert.svh"

module iabc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  iabc_pkg::stat_type stat,
   output logic               busy,
   output iabc_pkg::cmd_type  cmd
);

   iabc_pkg::state_type state_ff, state_in;
   logic [iabc_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iabc_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iabc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = iabc_pkg::ST_EXEC;
            end
         end
         iabc_pkg::ST_EXEC: begin
            if (stat.act == iabc_pkg::ACT_QUERY_AXIS && stat.axis_bound) begin
               state_in = iabc_pkg::ST_AXIS_READ;
            end else begin
               state_in = iabc_pkg::ST_IDLE;
            end
         end
         iabc_pkg::ST_AXIS_READ: state_in = iabc_pkg::ST_MULTIPLY;
         iabc_pkg::ST_MULTIPLY:  state_in = iabc_pkg::ST_DIV_CHECK;
         iabc_pkg::ST_DIV_CHECK: state_in = iabc_pkg::ST_DIVIDE;
         iabc_pkg::ST_DIVIDE: begin
            if (cnt_ff == iabc_pkg::CNT_BITS'(iabc_pkg::DIV_STEPS - 1)) begin
               state_in = iabc_pkg::ST_FINISH;
            end
         end
         iabc_pkg::ST_FINISH: state_in = iabc_pkg::ST_IDLE;
         default:             state_in = iabc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == iabc_pkg::ST_DIV_CHECK) begin
         cnt_in = '0;
      end else if (state_ff == iabc_pkg::ST_DIVIDE) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         iabc_pkg::ST_IDLE: begin
            busy          = 1'b0;
            cmd.latch_req = start;
         end
         iabc_pkg::ST_EXEC: begin
            case (stat.act)
               iabc_pkg::ACT_UPDATE_BUTTON: cmd.wr_button  = 1'b1;
               iabc_pkg::ACT_UPDATE_AXIS:   cmd.wr_axis    = 1'b1;
               iabc_pkg::ACT_END_FRAME:     cmd.end_frame  = 1'b1;
               iabc_pkg::ACT_QUERY_BUTTON:  cmd.rsp_button = 1'b1;
               iabc_pkg::ACT_QUERY_AXIS:    cmd.rsp_unbound = ~stat.axis_bound;
               default: ;
            endcase
         end
         iabc_pkg::ST_AXIS_READ: begin
            cmd.load_axis   = 1'b1;
            cmd.rd_negative = 1'b1;
         end
         iabc_pkg::ST_MULTIPLY:  cmd.multiply = 1'b1;
         iabc_pkg::ST_DIV_CHECK: cmd.div_init = 1'b1;
         iabc_pkg::ST_DIVIDE:    cmd.div_step = 1'b1;
         iabc_pkg::ST_FINISH:    cmd.rsp_axis = 1'b1;
         default: ;
      endcase
   end

   `IABC_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy,
      "accepted request did not make the block busy")
   `IABC_ASSERT_IMP(a_one_response, clock, reset, 1'b1,
      $onehot0({cmd.rsp_button, cmd.rsp_unbound, cmd.rsp_axis}),
      "more than one response issued in a cycle")
   `IABC_ASSERT_IMP(a_div_count, clock, reset, state_ff == iabc_pkg::ST_DIVIDE,
      cnt_ff < iabc_pkg::CNT_BITS'(iabc_pkg::DIV_STEPS), "divider ran past its last step")

endmodule

[hw/rtl/iabc_dp.sv]
// Datapath of the conditioner: configuration, button and axis stores, conditioning math.
// Depends on iabc_pkg, iabc_ram and the assertion macro header.
`include "input_axis_button_conditioner_assert.svh"

module iabc_dp #(
   parameter int BUTTON_COUNT = iabc_pkg::BUTTON_COUNT_DEF,
   parameter int AXIS_COUNT   = iabc_pkg::AXIS_COUNT_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [iabc_pkg::ACTION_BITS-1:0]         req_action,
   input  logic [iabc_pkg::INDEX_BITS-1:0]          req_index,
   input  logic                                     req_button_level,
   input  logic signed [iabc_pkg::SAMPLE_BITS-1:0]  req_axis_sample,
   input  logic [iabc_pkg::TIME_BITS-1:0]           req_event_time,
   input  logic                                     csr_we,
   input  logic [iabc_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [iabc_pkg::CSR_DATA_BITS-1:0]       csr_data,
   input  iabc_pkg::cmd_type                        cmd,
   output iabc_pkg::stat_type                       stat,
   output logic                                     rsp_valid,
   output logic                                     rsp_is_axis_answer,
   output logic                                     rsp_button_down,
   output logic                                     rsp_button_pressed,
   output logic signed [iabc_pkg::RESULT_BITS-1:0]  rsp_axis_result,
   output logic [iabc_pkg::TIME_BITS-1:0]           rsp_result_time
);

   localparam int BIW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
   localparam int AIW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
   localparam int AXW = iabc_pkg::SAMPLE_BITS + iabc_pkg::TIME_BITS;
   localparam int SB  = iabc_pkg::SAMPLE_BITS;
   localparam int TB  = iabc_pkg::TIME_BITS;
   localparam int RB  = iabc_pkg::RESULT_BITS;

   // Configuration registers.
   logic [iabc_pkg::SRC_BITS-1:0]     axis_source_ff, axis_source_in;
   logic                              axis_inverted_ff, axis_inverted_in;
   logic [iabc_pkg::MODE_BITS-1:0]    axis_range_mode_ff, axis_range_mode_in;
   logic [iabc_pkg::DZ_BITS-1:0]      dead_zone_ff, dead_zone_in;
   logic [iabc_pkg::SENS_BITS-1:0]    sensitivity_ff, sensitivity_in;
   logic [iabc_pkg::BTN_SEL_BITS-1:0] positive_button_ff, positive_button_in;
   logic [iabc_pkg::BTN_SEL_BITS-1:0] negative_button_ff, negative_button_in;

   always_comb begin
      axis_source_in     = axis_source_ff;
      axis_inverted_in   = axis_inverted_ff;
      axis_range_mode_in = axis_range_mode_ff;
      dead_zone_in       = dead_zone_ff;
      sensitivity_in     = sensitivity_ff;
      positive_button_in = positive_button_ff;
      negative_button_in = negative_button_ff;
      if (csr_we) begin
         case (csr_index)
            iabc_pkg::CSR_AXIS_SOURCE:     axis_source_in = csr_data[iabc_pkg::SRC_BITS-1:0];
            iabc_pkg::CSR_AXIS_INVERTED:   axis_inverted_in = csr_data[0];
            iabc_pkg::CSR_AXIS_RANGE_MODE:
               axis_range_mode_in = csr_data[iabc_pkg::MODE_BITS-1:0];
            iabc_pkg::CSR_DEAD_ZONE:       dead_zone_in = csr_data[iabc_pkg::DZ_BITS-1:0];
            iabc_pkg::CSR_SENSITIVITY:     sensitivity_in = csr_data[iabc_pkg::SENS_BITS-1:0];
            iabc_pkg::CSR_POSITIVE_BUTTON:
               positive_button_in = csr_data[iabc_pkg::BTN_SEL_BITS-1:0];
            iabc_pkg::CSR_NEGATIVE_BUTTON:
               negative_button_in = csr_data[iabc_pkg::BTN_SEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_source_ff     <= iabc_pkg::AXIS_SOURCE_RST;
         axis_inverted_ff   <= 1'b0;
         axis_range_mode_ff <= iabc_pkg::RANGE_FULL;
         dead_zone_ff       <= '0;
         sensitivity_ff     <= iabc_pkg::SENSITIVITY_RST;
         positive_button_ff <= iabc_pkg::BUTTON_SEL_RST;
         negative_button_ff <= iabc_pkg::BUTTON_SEL_RST;
      end else begin
         axis_source_ff     <= axis_source_in;
         axis_inverted_ff   <= axis_inverted_in;
         axis_range_mode_ff <= axis_range_mode_in;
         dead_zone_ff       <= dead_zone_in;
         sensitivity_ff     <= sensitivity_in;
         positive_button_ff <= positive_button_in;
         negative_button_ff <= negative_button_in;
      end
   end

   // Latched request.
   logic [iabc_pkg::ACTION_BITS-1:0] req_action_ff;
   logic [iabc_pkg::INDEX_BITS-1:0]  req_index_ff;
   logic                             req_level_ff;
   logic [SB-1:0]                    req_sample_ff;
   logic [TB-1:0]                    req_time_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_action_ff <= req_action;
         req_index_ff  <= req_index;
         req_level_ff  <= req_button_level;
         req_sample_ff <= req_axis_sample;
         req_time_ff   <= req_event_time;
      end
   end

   // Index decoding.
   logic           idx_button_ok, idx_axis_ok, axis_bound, pos_ok, neg_ok;
   logic [BIW-1:0] idx_button, pos_idx, neg_idx;
   logic [AIW-1:0] idx_axis, src_idx;

   assign idx_button_ok = 32'(req_index_ff) < BUTTON_COUNT;
   assign idx_axis_ok   = 32'(req_index_ff) < AXIS_COUNT;
   assign axis_bound    = 32'(axis_source_ff) < AXIS_COUNT;
   assign pos_ok        = 32'(positive_button_ff) < BUTTON_COUNT;
   assign neg_ok        = 32'(negative_button_ff) < BUTTON_COUNT;
   assign idx_button    = BIW'(32'(req_index_ff));
   assign idx_axis      = AIW'(32'(req_index_ff));
   assign src_idx       = AIW'(32'(axis_source_ff));
   assign pos_idx       = BIW'(32'(positive_button_ff));
   assign neg_idx       = BIW'(32'(negative_button_ff));

   assign stat.act        = iabc_pkg::action_type'(req_action_ff);
   assign stat.axis_bound = axis_bound;

   // Button levels and axis valid flags.
   logic [BUTTON_COUNT-1:0] button_now_ff, button_now_in;
   logic [BUTTON_COUNT-1:0] button_before_ff, button_before_in;
   logic [AXIS_COUNT-1:0]   axis_valid_ff, axis_valid_in;
   logic                    btn_we, axis_we;

   assign btn_we  = cmd.wr_button & idx_button_ok;
   assign axis_we = cmd.wr_axis & idx_axis_ok;

   always_comb begin
      button_now_in    = button_now_ff;
      button_before_in = button_before_ff;
      axis_valid_in    = axis_valid_ff;
      if (btn_we) begin
         button_now_in[idx_button] = req_level_ff;
      end
      if (cmd.end_frame) begin
         button_before_in = button_now_ff;
      end
      if (axis_we) begin
         axis_valid_in[idx_axis] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_now_ff    <= '0;
         button_before_ff <= '0;
         axis_valid_ff    <= '0;
      end else begin
         button_now_ff    <= button_now_in;
         button_before_ff <= button_before_in;
         axis_valid_ff    <= axis_valid_in;
      end
   end

   // Stamp and sample stores.
   logic [TB-1:0]  stamp_rdata;
   logic [AXW-1:0] axis_rdata;
   logic [BIW-1:0] stamp_raddr;

   assign stamp_raddr = cmd.rd_negative ? neg_idx : pos_idx;

   iabc_ram #(
      .WIDTH (TB),
      .DEPTH (BUTTON_COUNT)
   ) u_stamp_ram (
      .clock (clock),
      .we    (btn_we),
      .waddr (idx_button),
      .wdata (req_time_ff),
      .raddr (stamp_raddr),
      .rdata (stamp_rdata)
   );

   iabc_ram #(
      .WIDTH (AXW),
      .DEPTH (AXIS_COUNT)
   ) u_axis_ram (
      .clock (clock),
      .we    (axis_we),
      .waddr (idx_axis),
      .wdata ({req_sample_ff, req_time_ff}),
      .raddr (src_idx),
      .rdata (axis_rdata)
   );

   // Map the sample to Q.24 and split it into sign and magnitude.
   logic                               src_valid;
   logic [SB-1:0]                      sample_raw;
   logic [TB-1:0]                      axis_time_raw;
   logic signed [SB:0]                 s_ext, s_inv;
   logic signed [iabc_pkg::X_BITS-1:0] s_wide, x_val, x_abs;
   logic [iabc_pkg::MAG_BITS-1:0]      mag_in;

   assign src_valid     = axis_valid_ff[src_idx];
   assign sample_raw    = src_valid ? axis_rdata[AXW-1:TB] : '0;
   assign axis_time_raw = src_valid ? axis_rdata[TB-1:0] : '0;

   always_comb begin
      s_ext  = {sample_raw[SB-1], sample_raw};
      s_inv  = axis_inverted_ff ? -s_ext : s_ext;
      s_wide = {{(iabc_pkg::X_BITS - SB - 1){s_inv[SB]}}, s_inv};
      case (axis_range_mode_ff)
         iabc_pkg::RANGE_FORWARD:
            x_val = (s_wide <<< iabc_pkg::HALF_SHIFT) + iabc_pkg::HALF_Q24;
         iabc_pkg::RANGE_BACKWARD:
            x_val = (s_wide <<< iabc_pkg::HALF_SHIFT) - iabc_pkg::HALF_Q24;
         default:
            x_val = s_wide <<< iabc_pkg::FULL_SHIFT;
      endcase
      x_abs  = x_val[iabc_pkg::X_BITS-1] ? -x_val : x_val;
      mag_in = x_abs[iabc_pkg::MAG_BITS-1:0];
   end

   // Conditioning registers.
   logic [iabc_pkg::MAG_BITS-1:0]  mag_ff;
   logic                           neg_ff;
   logic [TB-1:0]                  axis_time_ff, pos_time_ff, neg_time_ff;
   logic [iabc_pkg::PROD_BITS-1:0] prod_ff;
   logic                           zero_ff, big_ff;
   logic [iabc_pkg::NUM_BITS-1:0]  rem_ff, dvs_ff;
   logic [RB-1:0]                  quo_ff;

   logic [iabc_pkg::DZQ_BITS-1:0]  dzq;
   logic [iabc_pkg::MAG_BITS-1:0]  den, diff;
   logic [iabc_pkg::NUM_BITS-1:0]  num;
   logic                           rem_ge;

   assign dzq    = {dead_zone_ff, {iabc_pkg::DZ_SHIFT{1'b0}}};
   assign den    = iabc_pkg::ONE_Q24 - {1'b0, dzq};
   assign diff   = mag_ff - {1'b0, dzq};
   assign num    = {prod_ff, {iabc_pkg::GAIN_SHIFT{1'b0}}};
   assign rem_ge = rem_ff >= dvs_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_axis) begin
         mag_ff       <= mag_in;
         neg_ff       <= x_val[iabc_pkg::X_BITS-1];
         axis_time_ff <= axis_time_raw;
         pos_time_ff  <= stamp_rdata;
      end
      if (cmd.multiply) begin
         neg_time_ff <= stamp_rdata;
         zero_ff     <= mag_ff <= {1'b0, dzq};
         prod_ff     <= iabc_pkg::PROD_BITS'(diff) * iabc_pkg::PROD_BITS'(sensitivity_ff);
      end
      // A quotient of 2^24 or more saturates; the divider then only needs 24 bits.
      if (cmd.div_init) begin
         big_ff <= {1'b0, num} >= {den, {RB{1'b0}}};
         rem_ff <= num;
         dvs_ff <= {den, {(iabc_pkg::NUM_BITS - iabc_pkg::MAG_BITS){1'b0}}};
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem_ge) begin
            rem_ff <= rem_ff - dvs_ff;
         end
         quo_ff <= {quo_ff[RB-2:0], rem_ge};
         dvs_ff <= dvs_ff >> 1;
      end
   end

   // Saturation and button override.
   logic [RB-1:0] cond_val, final_val;
   logic [TB-1:0] rt_axis, rt_pos, final_time;
   logic          pos_win, neg_win;

   always_comb begin
      if (zero_ff) begin
         cond_val = '0;
      end else if (neg_ff) begin
         cond_val = (big_ff || quo_ff > iabc_pkg::SAT_MIN) ? iabc_pkg::SAT_MIN
                                                          : (~quo_ff + 1'b1);
      end else begin
         cond_val = (big_ff || quo_ff[RB-1]) ? iabc_pkg::SAT_MAX : quo_ff;
      end
      rt_axis = axis_time_ff;
      pos_win = pos_ok && button_now_ff[pos_idx] && (pos_time_ff > rt_axis);
      rt_pos  = pos_win ? pos_time_ff : rt_axis;
      neg_win = neg_ok && button_now_ff[neg_idx] && (neg_time_ff > rt_pos);
      if (neg_win) begin
         final_val  = iabc_pkg::MINUS_ONE_Q15;
         final_time = neg_time_ff;
      end else if (pos_win) begin
         final_val  = iabc_pkg::PLUS_ONE_Q15;
         final_time = pos_time_ff;
      end else begin
         final_val  = cond_val;
         final_time = rt_axis;
      end
   end

   // Result registers.
   logic          rsp_valid_ff;
   logic          rsp_is_axis_ff, rsp_down_ff, rsp_pressed_ff;
   logic [RB-1:0] rsp_result_ff;
   logic [TB-1:0] rsp_time_ff;
   logic          q_down;

   assign q_down = idx_button_ok && button_now_ff[idx_button];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_button | cmd.rsp_unbound | cmd.rsp_axis;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_button) begin
         rsp_is_axis_ff <= 1'b0;
         rsp_down_ff    <= q_down;
         rsp_pressed_ff <= q_down && !button_before_ff[idx_button];
         rsp_result_ff  <= '0;
         rsp_time_ff    <= '0;
      end else if (cmd.rsp_unbound) begin
         rsp_is_axis_ff <= 1'b1;
         rsp_down_ff    <= 1'b0;
         rsp_pressed_ff <= 1'b0;
         rsp_result_ff  <= '0;
         rsp_time_ff    <= '0;
      end else if (cmd.rsp_axis) begin
         rsp_is_axis_ff <= 1'b1;
         rsp_down_ff    <= 1'b0;
         rsp_pressed_ff <= 1'b0;
         rsp_result_ff  <= final_val;
         rsp_time_ff    <= final_time;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_axis_answer = rsp_is_axis_ff;
   assign rsp_button_down    = rsp_down_ff;
   assign rsp_button_pressed = rsp_pressed_ff;
   assign rsp_axis_result    = rsp_result_ff;
   assign rsp_result_time    = rsp_time_ff;

   `IABC_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid_ff, !rsp_valid_ff,
      "result strobe held for more than one cycle")
   `IABC_ASSERT_IMP(a_pressed_needs_down, clock, reset, rsp_valid_ff && rsp_pressed_ff,
      rsp_down_ff, "button reported pressed but not held")
   `IABC_ASSERT_IMP(a_button_answer_clean, clock, reset, rsp_valid_ff && !rsp_is_axis_ff,
      rsp_result_ff == '0 && rsp_time_ff == '0, "button answer carries axis fields")

endmodule

[hw/rtl/input_axis_button_conditioner.sv]
// Top level of the input axis and button conditioner: controller plus datapath.
// Depends on iabc_pkg, iabc_ctrl, iabc_dp and iabc_ram.
//
// Usage. A request (req_action, req_index, req_button_level, req_axis_sample,
// req_event_time) is taken at a rising edge with start high and busy low.
// Updates and end-of-frame produce no result. A button query or an axis query
// produces one result on the rsp_ ports, marked by rsp_valid for exactly one
// cycle; the receiver cannot stall it and must take it then.
// A button query or unbound axis query is answered from the execute state, its
// result registered onto the rsp_ ports; updates and end-of-frame keep busy
// high only for the execute state. A bound axis query keeps busy high through
// decode, read, multiply, check, a 24-step one-bit-per-cycle restoring divider
// and finish, and its result appears in the cycle after; no new request is
// taken before that result, since the serial divider holds the block busy.
// Configuration goes through csr_valid/csr_ready with csr_index and csr_data;
// csr_ready is high while the block is idle.
// Reset (synchronous, active high) restores register defaults, clears all
// button levels and marks all stored axes empty, so they read as zero.
module input_axis_button_conditioner #(
   parameter int BUTTON_COUNT = iabc_pkg::BUTTON_COUNT_DEF,
   parameter int AXIS_COUNT   = iabc_pkg::AXIS_COUNT_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [iabc_pkg::ACTION_BITS-1:0]        req_action,
   input  logic [iabc_pkg::INDEX_BITS-1:0]         req_index,
   input  logic                                    req_button_level,
   input  logic signed [iabc_pkg::SAMPLE_BITS-1:0] req_axis_sample,
   input  logic [iabc_pkg::TIME_BITS-1:0]          req_event_time,
   output logic                                    rsp_valid,
   output logic                                    rsp_is_axis_answer,
   output logic                                    rsp_button_down,
   output logic                                    rsp_button_pressed,
   output logic signed [iabc_pkg::RESULT_BITS-1:0] rsp_axis_result,
   output logic [iabc_pkg::TIME_BITS-1:0]          rsp_result_time,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [iabc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [iabc_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   iabc_pkg::cmd_type  cmd;
   iabc_pkg::stat_type stat;
   logic               csr_we;

   assign csr_ready = ~busy;
   assign csr_we    = csr_valid & csr_ready;

   iabc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   iabc_dp #(
      .BUTTON_COUNT (BUTTON_COUNT),
      .AXIS_COUNT   (AXIS_COUNT)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_action         (req_action),
      .req_index          (req_index),
      .req_button_level   (req_button_level),
      .req_axis_sample    (req_axis_sample),
      .req_event_time     (req_event_time),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_is_axis_answer (rsp_is_axis_answer),
      .rsp_button_down    (rsp_button_down),
      .rsp_button_pressed (rsp_button_pressed),
      .rsp_axis_result    (rsp_axis_result),
      .rsp_result_time    (rsp_result_time)
   );

endmodule
